// ===== src/tcr_pkg.sv =====
// Shared types and constants for the text command recognizer.
`default_nettype none

package tcr_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  command_kind;
        logic [12:0] period_value;
    } t_out_item;

    localparam int unsigned PERIOD_W = 13;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_min;
        logic [PERIOD_W-1:0] period_max;
    } t_bounds;

    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_LED_ON  = 3'd1,
        KIND_LED_OFF = 3'd2,
        KIND_STATUS  = 3'd3,
        KIND_BLINK   = 3'd4
    } t_kind;

    // config register indexes
    localparam logic CFG_PERIOD_MIN = 1'b0;
    localparam logic CFG_PERIOD_MAX = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN_RST = 13'd50;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX_RST = 13'd5000;
    localparam logic [PERIOD_W-1:0] NUM_MAX        = 13'd8191;

    // keyword slots in the viable mask
    localparam logic [1:0] KW_LED_ON  = 2'd0;
    localparam logic [1:0] KW_LED_OFF = 2'd1;
    localparam logic [1:0] KW_STATUS  = 2'd2;
    localparam logic [1:0] KW_BLINK   = 2'd3;

    localparam logic [3:0] LEN_LED_ON  = 4'd6;
    localparam logic [3:0] LEN_LED_OFF = 4'd7;
    localparam logic [3:0] LEN_STATUS  = 4'd6;
    localparam logic [3:0] PREFIX_LEN  = 4'd6;
    localparam logic [3:0] POS_MAX     = 4'd15;

    // left aligned, first character in the top byte
    localparam logic [63:0] TXT_LED_ON  = {"led on", 16'h0000};
    localparam logic [63:0] TXT_LED_OFF = {"led off", 8'h00};
    localparam logic [63:0] TXT_STATUS  = {"status", 16'h0000};
    localparam logic [63:0] TXT_BLINK   = {"blink ", 16'h0000};

    function automatic logic [3:0] kw_len(input logic [1:0] k);
        logic [3:0] l;
        case (k)
            KW_LED_ON:  l = LEN_LED_ON;
            KW_LED_OFF: l = LEN_LED_OFF;
            KW_STATUS:  l = LEN_STATUS;
            default:    l = PREFIX_LEN;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [63:0] s;
        logic [5:0]  base;
        case (k)
            KW_LED_ON:  s = TXT_LED_ON;
            KW_LED_OFF: s = TXT_LED_OFF;
            KW_STATUS:  s = TXT_STATUS;
            default:    s = TXT_BLINK;
        endcase
        base = {3'd7 - p, 3'b000};
        return s[base +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== src/text_command_recognizer.sv =====
// Top level of the text command recognizer: handshakes, bounds registers, result register.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | one character or an end of line
//  out     | output    | o_out_valid / i_out_stall  | command kind and blink period
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | bound index and 13-bit value
//
// One beat per cycle while no end-of-line beat waits. The input register holds each beat
// for the line-state update; end-of-line beats then load the result register.
// Synchronous reset clears the line state and loads the bounds with 50 and 5000.
// Only end-of-line beats wait on a full result register; character beats never do.
`default_nettype none

module text_command_recognizer (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire tcr_pkg::t_in_item     i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output tcr_pkg::t_out_item         o_out_data,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire                        i_cfg_index,
    input  wire [tcr_pkg::PERIOD_W-1:0] i_cfg_data
);

    logic               r_in_vld;
    tcr_pkg::t_in_item  r_in;
    logic               r_out_vld;
    tcr_pkg::t_out_item r_out;
    tcr_pkg::t_bounds   r_bounds;
    tcr_pkg::t_out_item line_res;

    logic out_free;
    logic proc_fire;

    assign out_free  = !r_out_vld || !i_out_stall;
    assign proc_fire = r_in_vld && (!r_in.end_of_line || out_free);

    assign o_in_stall  = r_in_vld && !proc_fire;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    tcr_line u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_item   (r_in),
        .i_bounds (r_bounds),
        .o_res    (line_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_fire && r_in.end_of_line) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (proc_fire && r_in.end_of_line) begin
            r_out <= line_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.period_min <= tcr_pkg::PERIOD_MIN_RST;
            r_bounds.period_max <= tcr_pkg::PERIOD_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tcr_pkg::CFG_PERIOD_MIN: r_bounds.period_min <= i_cfg_data;
                tcr_pkg::CFG_PERIOD_MAX: r_bounds.period_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/tcr_line.sv =====
// Line state: keyword tracking, number build-up and end-of-line decode.
`default_nettype none

module tcr_line (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire tcr_pkg::t_in_item i_item,
    input  wire tcr_pkg::t_bounds  i_bounds,
    output tcr_pkg::t_out_item   o_res
);

    logic [3:0]  r_pos, n_pos;
    logic [3:0]  r_viable, n_viable;
    logic [12:0] r_acc, n_acc;
    logic        r_digit_seen, n_digit_seen;
    logic        r_num_bad, n_num_bad;

    logic [16:0] acc_next;
    logic        is_digit;
    logic        past_prefix;
    logic        blink_ok;

    assign past_prefix = (r_pos >= tcr_pkg::PREFIX_LEN);
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {13'd0, i_item.ch[3:0]};

    always_comb begin
        is_digit = i_item.ch inside {[8'h30:8'h39]};
        n_pos        = r_pos;
        n_viable     = r_viable;
        n_acc        = r_acc;
        n_digit_seen = r_digit_seen;
        n_num_bad    = r_num_bad;

        for (int k = 0; k < 4; k++) begin
            if (r_viable[k] && !(k == tcr_pkg::KW_BLINK && past_prefix)) begin
                if (r_pos >= tcr_pkg::kw_len(2'(k)) ||
                    i_item.ch != tcr_pkg::kw_char(2'(k), r_pos[2:0])) begin
                    n_viable[k] = 1'b0;
                end
            end
        end

        if (past_prefix) begin
            if (is_digit) begin
                n_digit_seen = 1'b1;
                // keep the old value and flag instead of wrapping
                if (acc_next > {4'd0, tcr_pkg::NUM_MAX}) begin
                    n_num_bad = 1'b1;
                end else begin
                    n_acc = acc_next[12:0];
                end
            end else begin
                n_num_bad = 1'b1;
            end
        end

        if (r_pos != tcr_pkg::POS_MAX) begin
            n_pos = r_pos + 4'd1;
        end
    end

    assign blink_ok = r_viable[tcr_pkg::KW_BLINK] && past_prefix && r_digit_seen &&
                      !r_num_bad && (r_acc >= i_bounds.period_min) &&
                      (r_acc <= i_bounds.period_max);

    always_comb begin
        o_res.command_kind = tcr_pkg::KIND_INVALID;
        o_res.period_value = '0;
        if (r_viable[tcr_pkg::KW_LED_ON] && r_pos == tcr_pkg::LEN_LED_ON) begin
            o_res.command_kind = tcr_pkg::KIND_LED_ON;
        end else if (r_viable[tcr_pkg::KW_LED_OFF] && r_pos == tcr_pkg::LEN_LED_OFF) begin
            o_res.command_kind = tcr_pkg::KIND_LED_OFF;
        end else if (r_viable[tcr_pkg::KW_STATUS] && r_pos == tcr_pkg::LEN_STATUS) begin
            o_res.command_kind = tcr_pkg::KIND_STATUS;
        end else if (blink_ok) begin
            o_res.command_kind = tcr_pkg::KIND_BLINK;
            o_res.period_value = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.end_of_line)) begin
            r_pos        <= '0;
            r_viable     <= '1;
            r_acc        <= '0;
            r_digit_seen <= 1'b0;
            r_num_bad    <= 1'b0;
        end else if (i_fire) begin
            r_pos        <= n_pos;
            r_viable     <= n_viable;
            r_acc        <= n_acc;
            r_digit_seen <= n_digit_seen;
            r_num_bad    <= n_num_bad;
        end
    end

endmodule

`default_nettype wire
